FILE: hw/rtl/ffa_pkg.sv
// Shared types, constants and codes for the first-fit allocator.
package ffa_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int ADDR_BITS = 32;
	localparam int DATA_W = 32;
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	typedef logic [DATA_W-1:0] word_t;
	typedef logic [DATA_W:0] wide_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam word_t ADDR_MASK = (ADDR_BITS >= DATA_W) ? '1 :
		word_t'((64'd1 << ADDR_BITS) - 64'd1);
	localparam wide_t ALIGN_ADD = wide_t'(7);
	localparam wide_t ALIGN_MASK = ~wide_t'(7);
	localparam word_t HEAP_BASE_RST = '0;
	localparam word_t HEAP_LIMIT_RST = word_t'(65536);
	localparam cnt_t MAX_COUNT = cnt_t'(MAX_ENTRIES);

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_NO_SPACE = 3'd1,
		ST_FULL = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_ZERO = 3'd4
	} status_t;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE = 1'b1
	} cmd_t;

	typedef enum logic {
		CFG_HEAP_BASE = 1'b0,
		CFG_HEAP_LIMIT = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CH_HOLD,
		CH_INSERT,
		CH_DELETE
	} chain_op_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_TAKE_PREV,
		CELL_TAKE_NEXT
	} cell_op_t;

	typedef struct packed {
		chain_op_t op;
		cnt_t slot;
		cnt_t count;
		word_t start;
		word_t len;
	} chain_cmd_t;

endpackage

FILE: hw/rtl/ffa_if.sv
// Request and response channel interfaces of the allocator.
interface ffa_req_if;
	logic valid;
	logic ready;
	logic cmd;
	ffa_pkg::word_t req_size;
	ffa_pkg::word_t free_address;

	modport source (output valid, output cmd, output req_size, output free_address,
		input ready);
	modport sink (input valid, input cmd, input req_size, input free_address,
		output ready);
endinterface

interface ffa_rsp_if;
	logic valid;
	logic ready;
	ffa_pkg::word_t block_address;
	logic [2:0] status;

	modport source (output valid, output block_address, output status, input ready);
	modport sink (input valid, input block_address, input status, output ready);
endinterface

FILE: hw/rtl/ffa_cell.sv
// One table cell holding the start and length of an allocated block.
module ffa_cell (
	input logic clk,
	input ffa_pkg::cell_op_t op,
	input ffa_pkg::word_t prev_start,
	input ffa_pkg::word_t prev_len,
	input ffa_pkg::word_t next_start,
	input ffa_pkg::word_t next_len,
	input ffa_pkg::word_t wr_start,
	input ffa_pkg::word_t wr_len,
	output ffa_pkg::word_t start,
	output ffa_pkg::word_t len
);
	import ffa_pkg::*;

	word_t start_q;
	word_t len_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_LOAD: begin
				start_q <= wr_start;
				len_q <= wr_len;
			end
			CELL_TAKE_PREV: begin
				start_q <= prev_start;
				len_q <= prev_len;
			end
			CELL_TAKE_NEXT: begin
				start_q <= next_start;
				len_q <= next_len;
			end
			default: begin
				start_q <= start_q;
				len_q <= len_q;
			end
		endcase
	end

	assign start = start_q;
	assign len = len_q;
endmodule

FILE: hw/rtl/ffa_chain.sv
// Row of table cells with insert and delete shifting and an indexed read port.
module ffa_chain (
	input logic clk,
	input ffa_pkg::chain_cmd_t cmd,
	input ffa_pkg::idx_t rd_idx,
	output ffa_pkg::word_t rd_start,
	output ffa_pkg::word_t rd_len
);
	import ffa_pkg::*;

	word_t start_w [MAX_ENTRIES];
	word_t len_w [MAX_ENTRIES];
	cell_op_t op_w [MAX_ENTRIES];

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		localparam cnt_t POS = cnt_t'(i);
		word_t prev_start;
		word_t prev_len;
		word_t next_start;
		word_t next_len;

		if (i == 0) begin : g_first
			assign prev_start = '0;
			assign prev_len = '0;
		end else begin : g_mid_lo
			assign prev_start = start_w[i-1];
			assign prev_len = len_w[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_last
			assign next_start = '0;
			assign next_len = '0;
		end else begin : g_mid_hi
			assign next_start = start_w[i+1];
			assign next_len = len_w[i+1];
		end

		always_comb begin
			op_w[i] = CELL_HOLD;
			case (cmd.op)
				CH_INSERT: begin
					if (POS == cmd.slot) begin
						op_w[i] = CELL_LOAD;
					end else if (POS > cmd.slot && POS <= cmd.count) begin
						op_w[i] = CELL_TAKE_PREV;
					end
				end
				CH_DELETE: begin
					if (POS >= cmd.slot && {1'b0, POS} + 1'b1 < {1'b0, cmd.count}) begin
						op_w[i] = CELL_TAKE_NEXT;
					end
				end
				default: op_w[i] = CELL_HOLD;
			endcase
		end

		ffa_cell u_cell (
			.clk(clk),
			.op(op_w[i]),
			.prev_start(prev_start),
			.prev_len(prev_len),
			.next_start(next_start),
			.next_len(next_len),
			.wr_start(cmd.start),
			.wr_len(cmd.len),
			.start(start_w[i]),
			.len(len_w[i])
		);
	end

	assign rd_start = start_w[rd_idx];
	assign rd_len = len_w[rd_idx];
endmodule

FILE: hw/rtl/first_fit_allocator_sorted_table.sv
// Top level of the first-fit allocator over a sorted table of allocated blocks.
//
//   channel  direction  payload                       handshake
//   req      in         cmd, req_size, free_address   valid/ready
//   rsp      out        block_address, status         valid/ready
//   cfg      in         cfg_index, cfg_data           cfg_we, no wait
//
// An allocate walks the table one entry per cycle from the chain read port, then
// does the fit check and the insert in S_FIT, which waits for a free response
// register. A free walks until the matching entry or the end of the table. Zero
// size and full table answer from S_RESP without a walk. A new request is taken
// only once the previous one is finished and the block is back in idle.
// Reset empties the table at once; cell contents are not cleared.
// A stalled response holds the finished item; the next request is taken once it is
// registered for delivery.
module first_fit_allocator_sorted_table (
	input logic clk,
	input logic arst_n,
	ffa_req_if.sink req,
	ffa_rsp_if.source rsp,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input ffa_pkg::word_t cfg_data
);
	import ffa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_FIT,
		S_FREE,
		S_RESP
	} state_t;

	state_t state_q;
	cnt_t count_q;
	cnt_t idx_q;
	wide_t pos_q;
	wide_t size_q;
	word_t addr_q;
	status_t res_status_q;
	word_t heap_base_q;
	word_t heap_limit_q;
	logic rsp_valid_q;
	word_t rsp_addr_q;
	status_t rsp_status_q;

	chain_cmd_t chain_cmd;
	word_t rd_start;
	word_t rd_len;
	wide_t s_w;
	wide_t e_w;
	wide_t limit_w;
	logic at_end;
	logic gap_fit;
	logic room;
	logic free_hit;
	logic out_free;
	logic accept;
	logic rsp_load;
	word_t rsp_load_addr;
	status_t rsp_load_status;

	ffa_chain u_chain (
		.clk(clk),
		.cmd(chain_cmd),
		.rd_idx(idx_q[IDX_W-1:0]),
		.rd_start(rd_start),
		.rd_len(rd_len)
	);

	always_comb begin
		s_w = {1'b0, rd_start};
		e_w = s_w + {1'b0, rd_len};
		limit_w = {1'b0, heap_limit_q & ADDR_MASK};
		at_end = (idx_q == count_q);
		gap_fit = (s_w >= pos_q) && ((s_w - pos_q) >= size_q);
		room = (pos_q <= limit_w) && ((limit_w - pos_q) >= size_q);
		free_hit = (rd_start == addr_q);
		out_free = !rsp_valid_q || rsp.ready;
		accept = req.valid && (state_q == S_IDLE);

		rsp_load = 1'b0;
		rsp_load_addr = '0;
		rsp_load_status = ST_OK;
		chain_cmd.op = CH_HOLD;
		chain_cmd.slot = idx_q;
		chain_cmd.count = count_q;
		chain_cmd.start = pos_q[DATA_W-1:0];
		chain_cmd.len = size_q[DATA_W-1:0];

		case (state_q)
			S_FIT: begin
				if (out_free) begin
					rsp_load = 1'b1;
					if (room) begin
						rsp_load_addr = pos_q[DATA_W-1:0];
						rsp_load_status = ST_OK;
						chain_cmd.op = CH_INSERT;
					end else begin
						rsp_load_status = ST_NO_SPACE;
					end
				end
			end
			S_FREE: begin
				if (out_free) begin
					if (at_end) begin
						rsp_load = 1'b1;
						rsp_load_status = ST_NOT_FOUND;
					end else if (free_hit) begin
						rsp_load = 1'b1;
						rsp_load_status = ST_OK;
						chain_cmd.op = CH_DELETE;
					end
				end
			end
			S_RESP: begin
				if (out_free) begin
					rsp_load = 1'b1;
					rsp_load_status = res_status_q;
				end
			end
			default: rsp_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q <= HEAP_BASE_RST;
			heap_limit_q <= HEAP_LIMIT_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_HEAP_BASE) begin
				heap_base_q <= cfg_data;
			end else begin
				heap_limit_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q <= '0;
			pos_q <= '0;
			size_q <= '0;
			addr_q <= '0;
			res_status_q <= ST_OK;
			rsp_valid_q <= 1'b0;
			rsp_addr_q <= '0;
			rsp_status_q <= ST_OK;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
				rsp_addr_q <= rsp_load_addr;
				rsp_status_q <= rsp_load_status;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						if (req.cmd == CMD_FREE) begin
							addr_q <= req.free_address & ADDR_MASK;
							state_q <= S_FREE;
						end else if (req.req_size == '0) begin
							res_status_q <= ST_ZERO;
							state_q <= S_RESP;
						end else if (count_q >= MAX_COUNT) begin
							res_status_q <= ST_FULL;
							state_q <= S_RESP;
						end else begin
							size_q <= ({1'b0, req.req_size} + ALIGN_ADD) & ALIGN_MASK;
							pos_q <= {1'b0, heap_base_q & ADDR_MASK};
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (at_end || gap_fit) begin
						state_q <= S_FIT;
					end else begin
						if (e_w > pos_q) begin
							pos_q <= e_w;
						end
						idx_q <= idx_q + 1'b1;
					end
				end
				S_FIT: begin
					if (out_free) begin
						if (room) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_FREE: begin
					if (at_end) begin
						if (out_free) begin
							state_q <= S_IDLE;
						end
					end else if (free_hit) begin
						if (out_free) begin
							count_q <= count_q - 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.block_address = rsp_addr_q;
	assign rsp.status = rsp_status_q;

`ifndef SYNTHESIS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request accepted while another item was in progress");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		chain_cmd.op == CH_INSERT |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the table by one entry");

	a_delete_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		chain_cmd.op == CH_DELETE |-> count_q != '0 && idx_q < count_q)
		else $error("delete issued on a missing entry");

	a_fail_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load && rsp_load_status != ST_OK |-> rsp_load_addr == '0)
		else $error("failed request carries a nonzero address");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> count_q < MAX_COUNT && idx_q <= count_q)
		else $error("table walk on a full table or past its end");
`endif
endmodule
